// File: rtl/core/e2q_pkg.sv
// ---------------------------------------------------------------------------
// e2q_pkg
// shared widths, constants and fixed-point helpers for euler_to_quaternion
// ---------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANG_W  = 16;
  localparam int QC_W   = 16;
  localparam int QW_W   = 15;
  localparam int NUM_W  = 33;
  localparam int RAD_W  = 33;
  localparam int ROOT_W = 31;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_PITCH = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROLL  = 2'd1;

  typedef logic signed [31:0] q30_t;

  localparam q30_t ONE_Q30 = 32'sh4000_0000;

  localparam logic signed [33:0] QUARTER_PI = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI    = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI2   = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI3   = 34'sd5059889139;

  localparam logic [ROOT_W-1:0] DEGEN_W = 31'd65536;
  localparam logic [14:0]       Q14_MAX = 15'd16384;

  localparam int SC_LAT  = 24;
  localparam int SQ_LAT  = 31;
  localparam int DV_LAT  = 16;
  localparam int TOT_LAT = SC_LAT + 3 + SQ_LAT + DV_LAT + 1;

  // q30 product truncated toward zero
  function automatic q30_t mulq(q30_t a, q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    if (p < 0) begin
      p = p + 64'sd1073741823;
    end
    return q30_t'(p >>> 30);
  endfunction

endpackage

// File: rtl/core/e2q_sincos.sv
// ---------------------------------------------------------------------------
// e2q_sincos
// pipelined sine and cosine: quadrant reduction, taylor terms, rotation
// ---------------------------------------------------------------------------
module e2q_sincos (
  input  logic                               clk,
  input  logic signed [e2q_pkg::ANG_W-1:0]   angle,
  output e2q_pkg::q30_t                      sin_val,
  output e2q_pkg::q30_t                      cos_val
);
  import e2q_pkg::*;

  typedef struct packed {
    logic [29:0] r2;
    logic [30:0] ms;
    logic [30:0] mc;
    logic        neg;
    q30_t        s;
    q30_t        c;
    logic [1:0]  quad;
  } sc_st_t;

  function automatic q30_t clamp_one(q30_t v);
    if (v > ONE_Q30) begin
      return ONE_Q30;
    end else if (v < -ONE_Q30) begin
      return -ONE_Q30;
    end
    return v;
  endfunction

  logic signed [33:0] r_full;
  logic signed [33:0] red;
  logic [1:0]         quad;
  logic signed [30:0] red_q;
  logic [1:0]         quad_q;
  logic [29:0]        mag;
  logic [59:0]        sq;

  // quadrant reduction
  always_comb begin
    r_full = {angle[ANG_W-1], angle, 17'd0};
    red    = r_full;
    quad   = 2'd0;
    priority if (r_full > QUARTER_PI) begin
      priority if (r_full - HALF_PI <= QUARTER_PI) begin
        red  = r_full - HALF_PI;
        quad = 2'd1;
      end else if (r_full - HALF_PI2 <= QUARTER_PI) begin
        red  = r_full - HALF_PI2;
        quad = 2'd2;
      end else begin
        red  = r_full - HALF_PI3;
        quad = 2'd3;
      end
    end else if (r_full < -QUARTER_PI) begin
      priority if (r_full + HALF_PI >= -QUARTER_PI) begin
        red  = r_full + HALF_PI;
        quad = 2'd3;
      end else if (r_full + HALF_PI2 >= -QUARTER_PI) begin
        red  = r_full + HALF_PI2;
        quad = 2'd2;
      end else begin
        red  = r_full + HALF_PI3;
        quad = 2'd1;
      end
    end else begin
      red  = r_full;
      quad = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    red_q  <= red[30:0];
    quad_q <= quad;
  end

  sc_st_t st [0:7];
  sc_st_t sa [1:7];
  sc_st_t sb [1:7];
  logic [30:0] pa_s [1:7];
  logic [30:0] pa_c [1:7];
  logic [30:0] pb_s [1:7];
  logic [30:0] pb_c [1:7];
  logic [30:0] eb_s [1:7];
  logic [30:0] eb_c [1:7];

  assign mag = red_q[30] ? 30'(-red_q) : 30'(red_q);
  assign sq  = 60'(mag) * 60'(mag);

  always_ff @(posedge clk) begin
    st[0].r2   <= sq[59:30];
    st[0].ms   <= 31'(mag);
    st[0].mc   <= 31'(ONE_Q30);
    st[0].neg  <= red_q[30];
    st[0].s    <= q30_t'(red_q);
    st[0].c    <= ONE_Q30;
    st[0].quad <= quad_q;
  end

  // one taylor term per three stages
  for (genvar g = 1; g <= 7; g++) begin : g_term
    localparam logic [7:0]  DS  = 8'((2 * g) * (2 * g + 1));
    localparam logic [7:0]  DC  = 8'((2 * g - 1) * (2 * g));
    localparam logic [31:0] RS  = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] RC  = 32'((64'd1 << 32) / DC);
    localparam logic        ODD = 1'(g % 2);

    logic [60:0] prod_s, prod_c;
    logic [62:0] e_s, e_c;
    logic [39:0] rm_s, rm_c;
    logic [30:0] q_s, q_c;
    sc_st_t      st_next;

    assign prod_s = 61'(st[g-1].ms) * 61'(st[g-1].r2);
    assign prod_c = 61'(st[g-1].mc) * 61'(st[g-1].r2);

    always_ff @(posedge clk) begin
      sa[g]   <= st[g-1];
      pa_s[g] <= prod_s[60:30];
      pa_c[g] <= prod_c[60:30];
    end

    assign e_s = 63'(pa_s[g]) * 63'(RS);
    assign e_c = 63'(pa_c[g]) * 63'(RC);

    always_ff @(posedge clk) begin
      sb[g]   <= sa[g];
      pb_s[g] <= pa_s[g];
      pb_c[g] <= pa_c[g];
      eb_s[g] <= e_s[62:32];
      eb_c[g] <= e_c[62:32];
    end

    // reciprocal estimate is low by at most one
    assign rm_s = 40'(pb_s[g]) - 40'(eb_s[g]) * 40'(DS);
    assign rm_c = 40'(pb_c[g]) - 40'(eb_c[g]) * 40'(DC);
    assign q_s  = eb_s[g] + 31'(rm_s >= 40'(DS));
    assign q_c  = eb_c[g] + 31'(rm_c >= 40'(DC));

    always_comb begin
      st_next    = sb[g];
      st_next.ms = q_s;
      st_next.mc = q_c;
      st_next.s  = (sb[g].neg ^ ODD) ? sb[g].s - q30_t'(q_s) : sb[g].s + q30_t'(q_s);
      st_next.c  = ODD ? sb[g].c - q30_t'(q_c) : sb[g].c + q30_t'(q_c);
    end

    always_ff @(posedge clk) begin
      st[g] <= st_next;
    end
  end

  q30_t rs, rc;

  always_comb begin
    unique case (st[7].quad)
      2'd0: begin
        rs = st[7].s;
        rc = st[7].c;
      end
      2'd1: begin
        rs = st[7].c;
        rc = -st[7].s;
      end
      2'd2: begin
        rs = -st[7].s;
        rc = -st[7].c;
      end
      default: begin
        rs = -st[7].c;
        rc = st[7].s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_val <= clamp_one(rs);
    cos_val <= clamp_one(rc);
  end

endmodule

// File: rtl/core/e2q_sqrt.sv
// ---------------------------------------------------------------------------
// e2q_sqrt
// pipelined integer square root of rad * 2^28, one root bit per stage
// ---------------------------------------------------------------------------
module e2q_sqrt (
  input  logic                         clk,
  input  logic [e2q_pkg::RAD_W-1:0]    rad,
  output logic [e2q_pkg::ROOT_W-1:0]   root
);
  import e2q_pkg::*;

  logic [61:0]       rem [0:ROOT_W-1];
  logic [ROOT_W-1:0] rt  [0:ROOT_W-1];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_bit
    localparam int I = ROOT_W - 1 - g;

    logic [61:0]       rem_in;
    logic [ROOT_W-1:0] rt_in;
    logic [61:0]       trial;

    if (g == 0) begin : g_first
      assign rem_in = {1'b0, rad, 28'd0};
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem[g-1];
      assign rt_in  = rt[g-1];
    end

    assign trial = (62'(rt_in) << (I + 1)) + (62'd1 << (2 * I));

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem[g] <= rem_in - trial;
        rt[g]  <= rt_in | (ROOT_W'(1) << I);
      end else begin
        rem[g] <= rem_in;
        rt[g]  <= rt_in;
      end
    end
  end

  assign root = rt[ROOT_W-1];

endmodule

// File: rtl/core/e2q_div.sv
// ---------------------------------------------------------------------------
// e2q_div
// pipelined rounded divide num*4096/w with saturation to q1.14
// ---------------------------------------------------------------------------
module e2q_div (
  input  logic                               clk,
  input  logic signed [e2q_pkg::NUM_W-1:0]   num,
  input  logic [e2q_pkg::ROOT_W-1:0]         w,
  output logic signed [e2q_pkg::QC_W-1:0]    quot
);
  import e2q_pkg::*;

  localparam int QB = 14;
  localparam int DW = 46;

  logic [NUM_W-1:0] mag;
  logic [DW-1:0]    nn;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign nn  = {1'b0, mag, 12'd0} + DW'(w >> 1);

  logic [DW-1:0]     rem [0:QB];
  logic [ROOT_W-1:0] wd  [0:QB];
  logic [QB-1:0]     qb  [0:QB];
  logic              neg [0:QB];
  logic              sat [0:QB];

  always_ff @(posedge clk) begin
    rem[0] <= nn;
    wd[0]  <= w;
    qb[0]  <= '0;
    neg[0] <= num[NUM_W-1];
    sat[0] <= nn >= {1'b0, w, 14'd0};
  end

  for (genvar g = 0; g < QB; g++) begin : g_bit
    localparam int I = QB - 1 - g;
    logic [DW-1:0] trial;

    assign trial = DW'(wd[g]) << I;

    always_ff @(posedge clk) begin
      wd[g+1]  <= wd[g];
      neg[g+1] <= neg[g];
      sat[g+1] <= sat[g];
      if (rem[g] >= trial) begin
        rem[g+1] <= rem[g] - trial;
        qb[g+1]  <= qb[g] | (QB'(1) << I);
      end else begin
        rem[g+1] <= rem[g];
        qb[g+1]  <= qb[g];
      end
    end
  end

  logic [14:0] qv;
  assign qv = sat[QB] ? Q14_MAX : {1'b0, qb[QB]};

  always_ff @(posedge clk) begin
    quot <= neg[QB] ? -QC_W'(qv) : QC_W'(qv);
  end

endmodule

// File: rtl/core/euler_to_quaternion.sv
// ---------------------------------------------------------------------------
// euler_to_quaternion
// yaw plus configured pitch and roll to a unit quaternion in q1.14
// ---------------------------------------------------------------------------
//  channel   signals                                     direction
//  command   start, busy, yaw_angle                      in (busy out)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   in (cfg_ready out)
//  result    done, quat_x/y/z/w, degenerate              out
//
//  one word is taken per cycle while busy is low; each word passes through
//  the sine/cosine pipeline, three product and sum stages, the square root
//  (one root bit per stage), the divider and the output register
//  rst is synchronous; busy is high for one cycle after reset
//  done pulses for one cycle per word; the receiver cannot stall
// ---------------------------------------------------------------------------
module euler_to_quaternion (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [e2q_pkg::ANG_W-1:0]   yaw_angle,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [e2q_pkg::IDX_W-1:0]          cfg_index,
  input  logic [e2q_pkg::ANG_W-1:0]          cfg_data,
  output logic                               done,
  output logic signed [e2q_pkg::QC_W-1:0]    quat_x,
  output logic signed [e2q_pkg::QC_W-1:0]    quat_y,
  output logic signed [e2q_pkg::QC_W-1:0]    quat_z,
  output logic [e2q_pkg::QW_W-1:0]           quat_w,
  output logic                               degenerate
);
  import e2q_pkg::*;

  logic signed [ANG_W-1:0] pitch_angle;
  logic signed [ANG_W-1:0] roll_angle;
  logic                    accept;
  logic [TOT_LAT:1]        vld;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign done      = vld[TOT_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      vld         <= '0;
      pitch_angle <= '0;
      roll_angle  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[TOT_LAT-1:1], accept};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PITCH: pitch_angle <= cfg_data;
          REG_ROLL:  roll_angle  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  q30_t s1, c1, s2, c2, s3, c3;

  e2q_sincos u_sc_pitch (.clk(clk), .angle(pitch_angle), .sin_val(s1), .cos_val(c1));
  e2q_sincos u_sc_yaw   (.clk(clk), .angle(yaw_angle),   .sin_val(s2), .cos_val(c2));
  e2q_sincos u_sc_roll  (.clk(clk), .angle(roll_angle),  .sin_val(s3), .cos_val(c3));

  // first products
  q30_t m12, m13, m23, ss12, cs12, c2s3, c1s3, s1c2, s1c3, s1s3;
  q30_t p1_s2, p1_s3, p1_c3;

  always_ff @(posedge clk) begin
    m12   <= mulq(c1, c2);
    m13   <= mulq(c1, c3);
    m23   <= mulq(c2, c3);
    ss12  <= mulq(s1, s2);
    cs12  <= mulq(c1, s2);
    c2s3  <= mulq(c2, s3);
    c1s3  <= mulq(c1, s3);
    s1c2  <= mulq(s1, c2);
    s1c3  <= mulq(s1, c3);
    s1s3  <= mulq(s1, s3);
    p1_s2 <= s2;
    p1_s3 <= s3;
    p1_c3 <= c3;
  end

  // second products
  q30_t t_sss, t_ssc, t_css, t_csc;
  q30_t p2_m12, p2_m13, p2_m23, p2_c2s3, p2_c1s3, p2_s1c2, p2_s1c3, p2_s1s3, p2_s2;

  always_ff @(posedge clk) begin
    t_sss   <= mulq(ss12, p1_s3);
    t_ssc   <= mulq(ss12, p1_c3);
    t_css   <= mulq(cs12, p1_s3);
    t_csc   <= mulq(cs12, p1_c3);
    p2_m12  <= m12;
    p2_m13  <= m13;
    p2_m23  <= m23;
    p2_c2s3 <= c2s3;
    p2_c1s3 <= c1s3;
    p2_s1c2 <= s1c2;
    p2_s1c3 <= s1c3;
    p2_s1s3 <= s1s3;
    p2_s2   <= p1_s2;
  end

  // radicand and numerators
  logic signed [34:0]      rad_full;
  logic [RAD_W-1:0]        rad;
  logic signed [NUM_W-1:0] nx, ny, nz;

  assign rad_full = 35'(ONE_Q30) + 35'(p2_m12) + 35'(p2_m13) - 35'(t_sss) + 35'(p2_m23);

  always_ff @(posedge clk) begin
    if (rad_full < 0) begin
      rad <= '0;
    end else if (rad_full > 35'sh1_0000_0000) begin
      rad <= 33'h1_0000_0000;
    end else begin
      rad <= rad_full[RAD_W-1:0];
    end
    nx <= NUM_W'(p2_c2s3) + NUM_W'(p2_c1s3) + NUM_W'(t_ssc);
    ny <= NUM_W'(p2_s1c2) + NUM_W'(p2_s1c3) + NUM_W'(t_css);
    nz <= NUM_W'(t_csc) + NUM_W'(p2_s2) - NUM_W'(p2_s1s3);
  end

  logic [ROOT_W-1:0] root;

  e2q_sqrt u_sqrt (.clk(clk), .rad(rad), .root(root));

  logic signed [NUM_W-1:0] nx_d [0:SQ_LAT-1];
  logic signed [NUM_W-1:0] ny_d [0:SQ_LAT-1];
  logic signed [NUM_W-1:0] nz_d [0:SQ_LAT-1];

  always_ff @(posedge clk) begin
    nx_d[0] <= nx;
    ny_d[0] <= ny;
    nz_d[0] <= nz;
    for (int k = 1; k < SQ_LAT; k++) begin
      nx_d[k] <= nx_d[k-1];
      ny_d[k] <= ny_d[k-1];
      nz_d[k] <= nz_d[k-1];
    end
  end

  logic signed [QC_W-1:0] qx, qy, qz;

  e2q_div u_div_x (.clk(clk), .num(nx_d[SQ_LAT-1]), .w(root), .quot(qx));
  e2q_div u_div_y (.clk(clk), .num(ny_d[SQ_LAT-1]), .w(root), .quot(qy));
  e2q_div u_div_z (.clk(clk), .num(nz_d[SQ_LAT-1]), .w(root), .quot(qz));

  logic [QW_W-1:0] qw_d [0:DV_LAT-1];
  logic            dg_d [0:DV_LAT-1];

  always_ff @(posedge clk) begin
    qw_d[0] <= QW_W'((32'(root) + 32'd32768) >> 16);
    dg_d[0] <= root < DEGEN_W;
    for (int k = 1; k < DV_LAT; k++) begin
      qw_d[k] <= qw_d[k-1];
      dg_d[k] <= dg_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    quat_x     <= dg_d[DV_LAT-1] ? '0 : qx;
    quat_y     <= dg_d[DV_LAT-1] ? '0 : qy;
    quat_z     <= dg_d[DV_LAT-1] ? '0 : qz;
    quat_w     <= qw_d[DV_LAT-1];
    degenerate <= dg_d[DV_LAT-1];
  end

endmodule

// File: rtl/core/e2q_checker.sv
// ---------------------------------------------------------------------------
// e2q_checker
// port-level checks on euler_to_quaternion results
// ---------------------------------------------------------------------------
module e2q_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               done,
  input logic signed [e2q_pkg::QC_W-1:0]    quat_x,
  input logic signed [e2q_pkg::QC_W-1:0]    quat_y,
  input logic signed [e2q_pkg::QC_W-1:0]    quat_z,
  input logic [e2q_pkg::QW_W-1:0]           quat_w,
  input logic                               degenerate
);

  // no word comes out right after reset
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("done raised right after reset");

  // degenerate word carries zero vector part and tiny w
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w <= 15'd1)
    else $error("degenerate word with nonzero vector part");

  // w never exceeds one
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    done |-> quat_w <= 15'd16384)
    else $error("quat_w above one");

  // vector part saturates at plus or minus one
  a_xyz_range: assert property (@(posedge clk) disable iff (rst)
    done |-> quat_x <= 16'sd16384 && quat_x >= -16'sd16384 &&
             quat_y <= 16'sd16384 && quat_y >= -16'sd16384 &&
             quat_z <= 16'sd16384 && quat_z >= -16'sd16384)
    else $error("vector component out of range");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);
